// ----- hdl/lsp_pkg.sv -----
// Shared constants, operation codes and register indexes of the link-state shortest-path block.
package lsp_pkg;

	localparam int MAX_NODES_DEF = 32;

	localparam int NODE_W = 6;
	localparam int COST_W = 16;
	localparam int DIST_W = 22;
	localparam int SEQ_W  = 31;
	localparam int CFG_W  = 7;

	localparam logic [1:0] OP_SET_LINK = 2'd0;
	localparam logic [1:0] OP_LSA      = 2'd1;
	localparam logic [1:0] OP_COMPUTE  = 2'd2;

	localparam logic CFG_ROOT  = 1'b0;
	localparam logic CFG_COUNT = 1'b1;

	localparam logic [CFG_W-1:0] COUNT_RESET = 7'd32;

endpackage

// ----- hdl/link_state_shortest_path.sv -----
// Top level of the link-state shortest-path block: link matrix, LSA sequence store and Dijkstra engine.
//
// The block holds a symmetric link-cost matrix and the newest LSA sequence number per source node,
// both in synchronous RAMs. After reset it runs a clearing pass over every entry of the link matrix
// (diagonal present with cost zero, every other link absent) and takes no input transfer until that
// pass is over. Items are handled one at a time: a set-link item is captured and then written once
// per direction on the single write port, and gives no result; an LSA header item reads the stored
// sequence number, waits for the output register to be free and gives one result. A compute item
// runs Dijkstra with n = clamped node_count: each round scans the n tentative distances through the
// distance RAM read port to pick the least unsettled node, then walks that node's matrix row one
// entry per cycle, relaxing neighbors with a read-modify-write of the distance RAM. The run is
// followed by n results, one per node, each read from the distance RAM and held while the output
// is stalled. Results leave through an output register, so the last result of one item may still
// wait while the next item is taken in. Configuration is written through a plain write port and
// takes effect at once.
module link_state_shortest_path #(
	parameter int MAX_NODES = lsp_pkg::MAX_NODES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [lsp_pkg::CFG_W-1:0]  cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 operation,
	input  logic [lsp_pkg::NODE_W-1:0] node_a,
	input  logic [lsp_pkg::NODE_W-1:0] node_b,
	input  logic                       link_present,
	input  logic [lsp_pkg::COST_W-1:0] link_cost,
	input  logic [lsp_pkg::SEQ_W-1:0]  sequence_req,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [lsp_pkg::NODE_W-1:0] node,
	output logic                       reachable,
	output logic [lsp_pkg::DIST_W-1:0] distance,
	output logic [lsp_pkg::NODE_W-1:0] parent,
	output logic                       has_parent,
	output logic                       accepted,
	output logic                       last
);

	import lsp_pkg::*;

	localparam int NW   = $clog2(MAX_NODES);
	localparam int CW   = $clog2(MAX_NODES + 1);
	localparam int LD   = MAX_NODES * MAX_NODES;
	localparam int LAW  = $clog2(LD);
	localparam int LW   = COST_W + 1;
	localparam int DW   = DIST_W + NW;

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_LINK1, S_LINK2, S_LSA_RD, S_LSA_WR,
		S_INIT, S_SEL, S_RELAX, S_OUT_RD, S_OUT_WR
	} state_t;

	state_t state_q;

	logic [NODE_W-1:0] root_q;
	logic [CFG_W-1:0]  count_q;

	logic [NODE_W-1:0] a_q, b_q;
	logic              pres_q;
	logic [COST_W-1:0] cost_q;
	logic [SEQ_W-1:0]  seq_q;

	logic [NW-1:0] row_q, col_q;
	logic [CW-1:0] n_q, cnt_q;
	logic [MAX_NODES-1:0] vis_q, known_q, pk_q, seq_valid_q;
	logic              found_q;
	logic [NW-1:0]     u_q;
	logic [DIST_W-1:0] min_q;
	logic              pipe_s1;
	logic [NW-1:0]     idx_s1;

	logic              out_valid_q;
	logic [NODE_W-1:0] node_q, parent_q;
	logic              reach_q, haspar_q, acc_q, last_q;
	logic [DIST_W-1:0] dist_q;

	// Memory ports.
	logic           link_we, link_re;
	logic [LAW-1:0] link_waddr, link_raddr;
	logic [LW-1:0]  link_wdata, link_rd;
	logic           dist_we;
	logic [NW-1:0]  dist_waddr;
	logic [DW-1:0]  dist_wdata, dist_rd;
	logic           seq_we, seq_re;
	logic [SEQ_W-1:0] seq_rd;

	logic              in_xfer, out_free, out_load, issue, root_ok, ends_ok, lsa_acc, relax_upd;
	logic [CW-1:0]     n_clamp;
	logic [DIST_W-1:0] rd_dist, d_new;
	logic [NW-1:0]     rd_par, cnt_idx;

	function automatic logic sequence_gt(input logic [SEQ_W-1:0] x, input logic [SEQ_W-1:0] y);
		return x > y;
	endfunction

	assign in_stall  = (state_q != S_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	// A new result enters the output register in this cycle.
	assign out_load  = ((state_q == S_LSA_WR) || (state_q == S_OUT_WR)) && out_free;
	assign cnt_idx   = cnt_q[NW-1:0];
	assign issue     = (cnt_q < n_q);
	assign root_ok   = ({1'b0, root_q} < (NODE_W + 1)'(n_q));
	assign ends_ok   = ({1'b0, node_a} < (NODE_W + 1)'(MAX_NODES))
		&& ({1'b0, node_b} < (NODE_W + 1)'(MAX_NODES));
	assign rd_dist   = dist_rd[DW-1:NW];
	assign rd_par    = dist_rd[NW-1:0];
	assign d_new     = min_q + DIST_W'(link_rd[COST_W-1:0]);
	assign relax_upd = (state_q == S_RELAX) && pipe_s1 && (idx_s1 != u_q) && link_rd[COST_W]
		&& !vis_q[idx_s1] && (!known_q[idx_s1] || d_new < rd_dist);
	assign lsa_acc   = ({1'b0, a_q} < (NODE_W + 1)'(MAX_NODES))
		&& (!seq_valid_q[a_q[NW-1:0]] || sequence_gt(seq_q, seq_rd));

	always_comb begin
		if (count_q == '0) begin
			n_clamp = CW'(1);
		end else if (count_q > CFG_W'(MAX_NODES)) begin
			n_clamp = CW'(MAX_NODES);
		end else begin
			n_clamp = CW'(count_q);
		end
	end

	always_comb begin
		link_we    = 1'b0;
		link_waddr = LAW'(row_q) * LAW'(MAX_NODES) + LAW'(col_q);
		link_wdata = {(row_q == col_q), {COST_W{1'b0}}};
		unique case (state_q)
			S_CLR: link_we = 1'b1;
			S_LINK1: begin
				link_we    = 1'b1;
				link_waddr = LAW'(a_q[NW-1:0]) * LAW'(MAX_NODES) + LAW'(b_q[NW-1:0]);
				link_wdata = {pres_q, pres_q ? cost_q : {COST_W{1'b0}}};
			end
			S_LINK2: begin
				link_we    = 1'b1;
				link_waddr = LAW'(b_q[NW-1:0]) * LAW'(MAX_NODES) + LAW'(a_q[NW-1:0]);
				link_wdata = {pres_q, pres_q ? cost_q : {COST_W{1'b0}}};
			end
			default: link_we = 1'b0;
		endcase
		link_re    = (state_q == S_RELAX) && issue;
		link_raddr = LAW'(u_q) * LAW'(MAX_NODES) + LAW'(cnt_idx);

		if (state_q == S_INIT) begin
			dist_we    = root_ok;
			dist_waddr = root_q[NW-1:0];
			dist_wdata = '0;
		end else begin
			dist_we    = relax_upd;
			dist_waddr = idx_s1;
			dist_wdata = {d_new, u_q};
		end

		seq_re = (state_q == S_LSA_RD);
		seq_we = (state_q == S_LSA_WR) && out_free && lsa_acc;
	end

	lsp_ram #(.WIDTH(LW), .DEPTH(LD)) u_link_ram (
		.clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
		.re(link_re), .raddr(link_raddr), .rdata(link_rd)
	);

	lsp_ram #(.WIDTH(DW), .DEPTH(MAX_NODES)) u_dist_ram (
		.clk(clk), .we(dist_we), .waddr(dist_waddr), .wdata(dist_wdata),
		.re(((state_q == S_SEL) || (state_q == S_RELAX)) && issue || (state_q == S_OUT_RD)),
		.raddr(cnt_idx), .rdata(dist_rd)
	);

	lsp_ram #(.WIDTH(SEQ_W), .DEPTH(MAX_NODES)) u_seq_ram (
		.clk(clk), .we(seq_we), .waddr(a_q[NW-1:0]), .wdata(seq_q),
		.re(seq_re), .raddr(a_q[NW-1:0]), .rdata(seq_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			root_q      <= '0;
			count_q     <= COUNT_RESET;
			row_q       <= '0;
			col_q       <= '0;
			n_q         <= '0;
			cnt_q       <= '0;
			vis_q       <= '0;
			known_q     <= '0;
			pk_q        <= '0;
			seq_valid_q <= '0;
			found_q     <= 1'b0;
			u_q         <= '0;
			pipe_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_ROOT:  root_q  <= cfg_data[NODE_W-1:0];
					CFG_COUNT: count_q <= cfg_data;
				endcase
			end
			if (out_valid_q && !out_stall && !out_load) begin
				out_valid_q <= 1'b0;
			end
			// A read issued in this cycle is looked at in the next one.
			pipe_s1 <= ((state_q == S_SEL) || (state_q == S_RELAX)) && issue;

			unique case (state_q)
				S_CLR: begin
					col_q <= (col_q == NW'(MAX_NODES - 1)) ? '0 : col_q + 1'b1;
					if (col_q == NW'(MAX_NODES - 1)) begin
						row_q <= row_q + 1'b1;
						if (row_q == NW'(MAX_NODES - 1)) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_IDLE: begin
					if (in_xfer) begin
						a_q    <= node_a;
						b_q    <= node_b;
						pres_q <= link_present;
						cost_q <= link_cost;
						seq_q  <= sequence_req;
						unique case (operation)
							OP_SET_LINK: state_q <= ends_ok ? S_LINK1 : S_IDLE;
							OP_LSA:      state_q <= S_LSA_RD;
							OP_COMPUTE: begin
								n_q     <= n_clamp;
								state_q <= S_INIT;
							end
							default:     state_q <= S_IDLE;
						endcase
					end
				end
				S_LINK1:  state_q <= S_LINK2;
				S_LINK2:  state_q <= S_IDLE;
				S_LSA_RD: state_q <= S_LSA_WR;
				S_LSA_WR: begin
					if (out_free) begin
						if (lsa_acc) begin
							seq_valid_q[a_q[NW-1:0]] <= 1'b1;
						end
						out_valid_q <= 1'b1;
						node_q      <= a_q;
						reach_q     <= 1'b0;
						dist_q      <= '0;
						parent_q    <= '0;
						haspar_q    <= 1'b0;
						acc_q       <= lsa_acc;
						last_q      <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_INIT: begin
					vis_q   <= '0;
					pk_q    <= '0;
					known_q <= root_ok ? (MAX_NODES'(1) << root_q[NW-1:0]) : '0;
					cnt_q   <= '0;
					found_q <= 1'b0;
					state_q <= S_SEL;
				end
				S_SEL: begin
					if (issue) begin
						cnt_q   <= cnt_q + 1'b1;
						idx_s1  <= cnt_idx;
					end
					// Ascending scan with a strict compare keeps ties on the lower node.
					if (pipe_s1 && !vis_q[idx_s1] && known_q[idx_s1]
							&& (!found_q || rd_dist < min_q)) begin
						found_q <= 1'b1;
						u_q     <= idx_s1;
						min_q   <= rd_dist;
					end
					if (!issue && !pipe_s1) begin
						cnt_q <= '0;
						if (found_q) begin
							vis_q[u_q] <= 1'b1;
							state_q    <= S_RELAX;
						end else begin
							state_q <= S_OUT_RD;
						end
					end
				end
				S_RELAX: begin
					if (issue) begin
						cnt_q   <= cnt_q + 1'b1;
						idx_s1  <= cnt_idx;
					end
					if (relax_upd) begin
						known_q[idx_s1] <= 1'b1;
						pk_q[idx_s1]    <= 1'b1;
					end
					if (!issue && !pipe_s1) begin
						cnt_q   <= '0;
						found_q <= 1'b0;
						state_q <= S_SEL;
					end
				end
				S_OUT_RD: state_q <= S_OUT_WR;
				S_OUT_WR: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						node_q      <= NODE_W'(cnt_q);
						reach_q     <= vis_q[cnt_idx];
						dist_q      <= vis_q[cnt_idx] ? rd_dist : '0;
						parent_q    <= (vis_q[cnt_idx] && pk_q[cnt_idx]) ? NODE_W'(rd_par) : '0;
						haspar_q    <= vis_q[cnt_idx] && pk_q[cnt_idx];
						acc_q       <= 1'b0;
						last_q      <= (cnt_q + 1'b1 == n_q);
						cnt_q       <= cnt_q + 1'b1;
						state_q     <= (cnt_q + 1'b1 == n_q) ? S_IDLE : S_OUT_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign node       = node_q;
	assign reachable  = reach_q;
	assign distance   = dist_q;
	assign parent     = parent_q;
	assign has_parent = haspar_q;
	assign accepted   = acc_q;
	assign last       = last_q;

	// The matrix clearing pass takes no input transfer.
	assert property (@(posedge clk) disable iff (!arst_n) (state_q == S_CLR) |-> in_stall)
		else $error("input taken during clearing pass");

	// The node being relaxed has already been settled.
	assert property (@(posedge clk) disable iff (!arst_n) (state_q == S_RELAX) |-> vis_q[u_q])
		else $error("relaxing from an unsettled node");

	// An unreachable node reports no distance and no parent.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !reach_q) |-> (dist_q == '0) && !haspar_q)
		else $error("unreachable result carries a path");

	// An accepted LSA result always closes its item.
	assert property (@(posedge clk) disable iff (!arst_n) (out_valid_q && acc_q) |-> last_q)
		else $error("accepted LSA result not marked last");

endmodule

// ----- hdl/lsp_ram.sv -----
// Generic single-write, single-read synchronous RAM with a registered read port.
module lsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
